// ===== rtl/skt_pkg.sv =====
package skt_pkg;

	localparam int DEPTH    = 256;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = IDX_W + 1;
	localparam int KIND_W   = 3;
	localparam int KEY_W    = 32;
	localparam int PAY_W    = 32;
	localparam int INDEX_W  = 8;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_FIND   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_OUT_OF_RANGE = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} skt_entry_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		skt_entry_t       wdata;
	} skt_mem_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic [KEY_W-1:0]    key_out;
		logic [PAY_W-1:0]    payload_out;
		logic [CNT_W-1:0]    count;
	} skt_result_t;

endpackage

// ===== rtl/skt_if.sv =====
interface skt_req_if import skt_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [KEY_W-1:0]   key;
	logic [PAY_W-1:0]   payload;
	logic [INDEX_W-1:0] index;

	modport source (output valid, kind, key, payload, index, input ready);
	modport sink   (input valid, kind, key, payload, index, output ready);
endinterface

interface skt_rsp_if import skt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    position;
	logic [KEY_W-1:0]    key_out;
	logic [PAY_W-1:0]    payload_out;
	logic [CNT_W-1:0]    count;

	modport source (output valid, status, position, key_out, payload_out, count, input ready);
	modport sink   (input valid, status, position, key_out, payload_out, count, output ready);
endinterface

// ===== rtl/sorted_key_table.sv =====
// Channel  Role   Beat contents
// -------  -----  ----------------------------------------------------------
// req      sink   kind, key, payload, index: one operation on the table
// rsp      source status, position, key_out, payload_out, count: one result
//
// Every request beat yields exactly one response beat, in order. A find
// or erase does a binary search over the live entries; an insert walks down
// from the top, moving up one slot each entry whose key is not smaller, and
// an erase that hits moves every later entry down one slot. A read by index
// does one memory read. No new request is taken until the result has passed
// to the output register. Reset clears the entry count and the control state
// only; the memory needs no clearing pass. A stalled response holds the
// engine in its final state, while a finished result sits in the output register.
module sorted_key_table import skt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);

	skt_mem_req_t mem_req;
	skt_entry_t   mem_rdata;
	skt_result_t  res;
	logic         res_valid;
	logic         res_ack;

	logic         out_valid_q;
	skt_result_t  out_q;

	// Keys and payloads share one memory word, so a move is one read and
	// one write of the whole entry.
	skt_ram #(
		.WIDTH ($bits(skt_entry_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	skt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res       (res),
		.res_valid (res_valid),
		.res_ack   (res_ack)
	);

	// The output register takes a new result when it is empty or its current
	// beat leaves in this cycle.
	assign res_ack = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.position    = out_q.position;
	assign rsp.key_out     = out_q.key_out;
	assign rsp.payload_out = out_q.payload_out;
	assign rsp.count       = out_q.count;

endmodule

// ===== rtl/skt_ram.sv =====
module skt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/skt_ctrl.sv =====
module skt_ctrl import skt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	skt_req_if.sink      req,
	output skt_mem_req_t mem_req,
	input  skt_entry_t   mem_rdata,
	output skt_result_t  res,
	output logic         res_valid,
	input  logic         res_ack
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_ERS_RD,
		S_ERS_MV,
		S_RD_DATA,
		S_DONE
	} state_t;

	state_t              state_q;
	logic [KIND_W-1:0]   kind_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAY_W-1:0]    pay_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    j_q;
	logic [CNT_W-1:0]    lo_q;
	logic [CNT_W-1:0]    hix_q;
	logic [IDX_W-1:0]    mid_q;
	skt_result_t         res_q;

	logic                accept;
	logic                idx_in_range;
	logic [CNT_W:0]      mid_sum;
	logic [IDX_W-1:0]    mid;
	logic                search_open;
	logic                ins_shift;
	logic [CNT_W:0]      j_plus1;
	logic [CNT_W:0]      j_plus2;
	logic                ers_more;
	logic                ers_more_next;
	skt_result_t         res_start;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign idx_in_range  = (CNT_W'(req.index) < cnt_q);
	// Midpoint of the closed interval [lo, hix - 1], rounded down.
	assign mid_sum       = (CNT_W+1)'(lo_q) + (CNT_W+1)'(hix_q) - (CNT_W+1)'(1);
	assign mid           = mid_sum[IDX_W:1];
	assign search_open   = (lo_q < hix_q);
	assign ins_shift     = (mem_rdata.key >= key_q);
	assign j_plus1       = (CNT_W+1)'(j_q) + (CNT_W+1)'(1);
	assign j_plus2       = (CNT_W+1)'(j_q) + (CNT_W+1)'(2);
	assign ers_more      = (j_plus1 < (CNT_W+1)'(cnt_q));
	assign ers_more_next = (j_plus2 < (CNT_W+1)'(cnt_q));

	// Result as it stands when a request is taken; the walk fills in the rest.
	always_comb begin
		res_start        = '0;
		res_start.status = STATUS_OK;
		res_start.count  = cnt_q;
		case (req.kind)
			KIND_INSERT: begin
				if (cnt_q == CNT_W'(DEPTH)) begin
					res_start.status = STATUS_FULL;
				end
			end
			KIND_CLEAR: begin
				res_start.count = '0;
			end
			KIND_READ: begin
				if (!idx_in_range) begin
					res_start.status = STATUS_OUT_OF_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_req       = '0;
		mem_req.wdata = mem_rdata;
		case (state_q)
			S_IDLE: begin
				if (accept && req.kind == KIND_READ && idx_in_range) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = req.index[IDX_W-1:0];
				end
			end
			S_INS_RD: begin
				if (j_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = IDX_W'(j_q - CNT_W'(1));
				end
			end
			S_INS_CMP: begin
				if (ins_shift) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = j_q[IDX_W-1:0];
					if (j_q > CNT_W'(1)) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = IDX_W'(j_q - CNT_W'(2));
					end
				end
			end
			S_INS_PUT: begin
				mem_req.we            = 1'b1;
				mem_req.waddr         = j_q[IDX_W-1:0];
				mem_req.wdata.key     = key_q;
				mem_req.wdata.payload = pay_q;
			end
			S_SRCH_RD: begin
				if (search_open) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = mid;
				end
			end
			S_ERS_RD: begin
				if (ers_more) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = j_plus1[IDX_W-1:0];
				end
			end
			S_ERS_MV: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = j_q[IDX_W-1:0];
				if (ers_more_next) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = j_plus2[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			kind_q  <= '0;
			key_q   <= '0;
			pay_q   <= '0;
			idx_q   <= '0;
			j_q     <= '0;
			lo_q    <= '0;
			hix_q   <= '0;
			mid_q   <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q <= req.kind;
						key_q  <= req.key;
						pay_q  <= req.payload;
						idx_q  <= req.index;
						res_q  <= res_start;
						case (req.kind)
							KIND_INSERT: begin
								if (cnt_q == CNT_W'(DEPTH)) begin
									state_q <= S_DONE;
								end else begin
									j_q     <= cnt_q;
									state_q <= S_INS_RD;
								end
							end
							KIND_FIND, KIND_ERASE: begin
								lo_q    <= '0;
								hix_q   <= cnt_q;
								state_q <= S_SRCH_RD;
							end
							KIND_CLEAR: begin
								cnt_q   <= '0;
								state_q <= S_DONE;
							end
							KIND_READ: begin
								if (idx_in_range) begin
									state_q <= S_RD_DATA;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= (j_q == '0) ? S_INS_PUT : S_INS_CMP;
				end
				S_INS_CMP: begin
					if (ins_shift) begin
						j_q     <= j_q - CNT_W'(1);
						state_q <= (j_q > CNT_W'(1)) ? S_INS_CMP : S_INS_PUT;
					end else begin
						state_q <= S_INS_PUT;
					end
				end
				S_INS_PUT: begin
					cnt_q             <= cnt_q + CNT_W'(1);
					res_q.position    <= POS_W'(j_q);
					res_q.key_out     <= key_q;
					res_q.payload_out <= pay_q;
					res_q.count       <= cnt_q + CNT_W'(1);
					state_q           <= S_DONE;
				end
				S_SRCH_RD: begin
					if (search_open) begin
						mid_q   <= mid;
						state_q <= S_SRCH_CMP;
					end else begin
						res_q.status <= STATUS_NOT_FOUND;
						state_q      <= S_DONE;
					end
				end
				S_SRCH_CMP: begin
					if (mem_rdata.key == key_q) begin
						res_q.position    <= POS_W'(mid_q);
						res_q.key_out     <= mem_rdata.key;
						res_q.payload_out <= mem_rdata.payload;
						if (kind_q == KIND_ERASE) begin
							j_q     <= CNT_W'(mid_q);
							state_q <= S_ERS_RD;
						end else begin
							state_q <= S_DONE;
						end
					end else if (mem_rdata.key < key_q) begin
						lo_q    <= CNT_W'(mid_q) + CNT_W'(1);
						state_q <= S_SRCH_RD;
					end else begin
						hix_q   <= CNT_W'(mid_q);
						state_q <= S_SRCH_RD;
					end
				end
				S_ERS_RD: begin
					if (ers_more) begin
						state_q <= S_ERS_MV;
					end else begin
						cnt_q       <= cnt_q - CNT_W'(1);
						res_q.count <= cnt_q - CNT_W'(1);
						state_q     <= S_DONE;
					end
				end
				S_ERS_MV: begin
					j_q <= j_plus1[CNT_W-1:0];
					if (!ers_more_next) begin
						cnt_q       <= cnt_q - CNT_W'(1);
						res_q.count <= cnt_q - CNT_W'(1);
						state_q     <= S_DONE;
					end
				end
				S_RD_DATA: begin
					res_q.position    <= POS_W'(idx_q);
					res_q.key_out     <= mem_rdata.key;
					res_q.payload_out <= mem_rdata.payload;
					state_q           <= S_DONE;
				end
				S_DONE: begin
					if (res_ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res       = res_q;
	assign res_valid = (state_q == S_DONE);

endmodule

// ===== rtl/skt_checker.sv =====
module skt_checker import skt_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [POS_W-1:0]    position,
	input logic [KEY_W-1:0]    key_out,
	input logic [PAY_W-1:0]    payload_out,
	input logic [CNT_W-1:0]    count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response beat dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while an operation is in flight");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_FULL |-> count == CNT_W'(DEPTH))
		else $error("full status with a table that is not full");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_OUT_OF_RANGE |->
			position == '0 && key_out == '0 && payload_out == '0)
		else $error("out of range result carries data");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_ready   (rsp.ready),
	.status      (rsp.status),
	.position    (rsp.position),
	.key_out     (rsp.key_out),
	.payload_out (rsp.payload_out),
	.count       (rsp.count)
);

// ===== tb/sv/testbench.sv =====
module testbench;
	import skt_pkg::*;

	// The kinds above read by index do nothing in the block except return the
	// current count with an ok status.
	localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

	localparam int RANDOM_OPS     = 820;
	localparam int FULL_AT        = 600;   // random beat count that starts the fill-to-full run
	localparam int HOLD_AT        = 200;   // request beats sent before the long response stall
	localparam int HOLD_CYCLES    = 600;
	localparam int DRAIN_CYCLES   = 300;
	localparam int WATCHDOG_LIMIT = 5000;

	// One request beat as the sender sees it.
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
		logic [INDEX_W-1:0] index;
	} op_t;

	// The scoreboard keeps its own sorted table. Every accepted request is
	// applied to that table at once, which gives the one response beat it
	// must produce; those wait in order until the response side sees them.
	class table_scoreboard;
		logic [KEY_W-1:0] keys [DEPTH];
		logic [PAY_W-1:0] pays [DEPTH];
		int               fill;
		skt_result_t      expected_q [$];
		int               errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		// Binary search over the live entries. Among equal keys it returns
		// whichever one the probes happen to hit first, just like the block.
		function int search(logic [KEY_W-1:0] k);
			int lo, hi, mid;
			lo = 0;
			hi = fill - 1;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (keys[mid] == k)
					return mid;
				if (keys[mid] < k)
					lo = mid + 1;
				else
					hi = mid - 1;
			end
			return -1;
		endfunction

		function void note_op(op_t op);
			skt_result_t r;
			int at, j;
			r = '0;
			case (op.kind)
				KIND_INSERT: begin
					if (fill >= DEPTH) begin
						r.status = STATUS_FULL;
					end else begin
						// Slide past every entry whose key is not smaller, so
						// the newest of equal keys ends up first.
						j = fill;
						while (j > 0 && keys[j-1] >= op.key) begin
							keys[j] = keys[j-1];
							pays[j] = pays[j-1];
							j--;
						end
						keys[j]       = op.key;
						pays[j]       = op.payload;
						fill++;
						r.position    = POS_W'(j);
						r.key_out     = op.key;
						r.payload_out = op.payload;
					end
				end
				KIND_FIND, KIND_ERASE: begin
					at = search(op.key);
					if (at < 0) begin
						r.status = STATUS_NOT_FOUND;
					end else begin
						r.position    = POS_W'(at);
						r.key_out     = keys[at];
						r.payload_out = pays[at];
						if (op.kind == KIND_ERASE) begin
							for (j = at; j + 1 < fill; j++) begin
								keys[j] = keys[j+1];
								pays[j] = pays[j+1];
							end
							fill--;
						end
					end
				end
				KIND_CLEAR: begin
					fill = 0;
				end
				KIND_READ: begin
					if (op.index >= fill) begin
						r.status = STATUS_OUT_OF_RANGE;
					end else begin
						r.position    = op.index;
						r.key_out     = keys[op.index];
						r.payload_out = pays[op.index];
					end
				end
				default: begin
				end
			endcase
			r.count = CNT_W'(fill);
			expected_q.push_back(r);
		endfunction

		function void check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(skt_result_t got);
			skt_result_t want;
			if (expected_q.size() == 0) begin
				$error("response beat with nothing outstanding: status %0d count %0d",
					got.status, got.count);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			check_field("status", KEY_W'(want.status), KEY_W'(got.status));
			check_field("position", KEY_W'(want.position), KEY_W'(got.position));
			check_field("key_out", want.key_out, got.key_out);
			check_field("payload_out", want.payload_out, got.payload_out);
			check_field("count", KEY_W'(want.count), KEY_W'(got.count));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	skt_req_if req();
	skt_rsp_if rsp();

	sorted_key_table DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #2 clk = ~clk;

	table_scoreboard sb;
	int              sent_count;
	int              burst_left;

	// Drive one request beat and hold it until the block takes it. Ready is
	// read right after the edge, so it is the value the edge itself saw. The
	// sender works in bursts: when one ends, valid drops for a random gap.
	// Valid is lowered here between bursts, never in the same step it is raised again.
	task automatic send_op(input op_t op);
		int gap;
		req.valid   <= 1'b1;
		req.kind    <= op.kind;
		req.key     <= op.key;
		req.payload <= op.payload;
		req.index   <= op.index;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_op(op);
		sent_count++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 6);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			// Now and then a long burst gives a stretch with no sender idling.
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 20);
		end
	endtask

	function automatic op_t make_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
		logic [PAY_W-1:0] payload, logic [INDEX_W-1:0] index);
		op_t op;
		op.kind    = kind;
		op.key     = key;
		op.payload = payload;
		op.index   = index;
		return op;
	endfunction

	// Keys come mostly from two narrow pools at the ends of the range, so
	// duplicates are common, or from entries already in the table, so finds
	// and erases hit. The rest are fully random.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				return $urandom_range(0, 15);
			end
			3: begin
				return 32'hFFFF_FFFF - $urandom_range(0, 15);
			end
			4, 5, 6: begin
				if (sb.fill > 0)
					return sb.keys[$urandom_range(0, sb.fill - 1)];
				return $urandom();
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	// Read positions are mostly live slots, sometimes exactly the count (the
	// first slot out of range), and sometimes anywhere in the field.
	function automatic logic [INDEX_W-1:0] pick_index();
		case ($urandom_range(0, 3))
			0: begin
				return INDEX_W'($urandom_range(0, 255));
			end
			1: begin
				return INDEX_W'((sb.fill > 255) ? 255 : sb.fill);
			end
			default: begin
				if (sb.fill > 0)
					return INDEX_W'($urandom_range(0, sb.fill - 1));
				return INDEX_W'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// A random operation that keeps the table near the size given: once it
	// is there, most inserts turn into erases.
	function automatic op_t pick_op(int cap);
		op_t op;
		int  roll;
		op.key     = pick_key();
		op.payload = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom();
		op.index   = pick_index();
		roll       = $urandom_range(0, 99);
		if (roll < 45)
			op.kind = KIND_INSERT;
		else if (roll < 62)
			op.kind = KIND_FIND;
		else if (roll < 80)
			op.kind = KIND_ERASE;
		else if (roll < 96)
			op.kind = KIND_READ;
		else if (roll < 98)
			op.kind = KIND_CLEAR;
		else
			op.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
		if (op.kind == KIND_INSERT && sb.fill >= cap && $urandom_range(0, 2) != 0)
			op.kind = KIND_ERASE;
		return op;
	endfunction

	// Grows the table to its full depth, knocks on the full limit, works at
	// both ends of the full table, then clears it.
	task automatic fill_to_full();
		op_t op;
		while (sb.fill < DEPTH) begin
			op      = pick_op(DEPTH);
			op.kind = KIND_INSERT;
			send_op(op);
		end
		repeat (3) send_op(make_op(KIND_INSERT, $urandom(), $urandom(), 0));
		send_op(make_op(KIND_READ, 0, 0, INDEX_W'(DEPTH - 1)));
		send_op(make_op(KIND_READ, 0, 0, 0));
		send_op(make_op(KIND_FIND, sb.keys[0], 0, 0));
		send_op(make_op(KIND_FIND, sb.keys[DEPTH-1], 0, 0));
		send_op(make_op(KIND_ERASE, sb.keys[DEPTH-1], 0, 0));
		send_op(make_op(KIND_INSERT, 32'hFFFF_FFFF, $urandom(), 0));
		repeat (20) begin
			op = pick_op(DEPTH);
			if (op.kind == KIND_CLEAR)
				op.kind = KIND_READ;
			send_op(op);
		end
		send_op(make_op(KIND_ERASE, sb.keys[0], 0, 0));
		send_op(make_op(KIND_CLEAR, 0, 0, 0));
	endtask

	// Response side. Each accepted beat is checked against the oldest
	// expectation. Ready follows a pattern that changes mode now and then:
	// always ready, mostly ready, one cycle in three, or mostly stalled.
	// Once, after enough request beats, ready stays low for a long stretch
	// while the sender keeps offering, so the block backs up to its input.
	initial begin : rsp_side
		skt_result_t got;
		int          mode, mode_left, phase, hold_left;
		bit          held, nxt;
		mode      = 0;
		mode_left = 0;
		phase     = 0;
		hold_left = 0;
		held      = 1'b0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready) begin
				got.status      = rsp.status;
				got.position    = rsp.position;
				got.key_out     = rsp.key_out;
				got.payload_out = rsp.payload_out;
				got.count       = rsp.count;
				sb.check_result(got);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 200);
			end
			mode_left--;
			phase = (phase + 1) % 3;
			case (mode)
				0: nxt = 1'b1;
				1: nxt = ($urandom_range(0, 3) != 0);
				2: nxt = (phase == 0);
				default: nxt = ($urandom_range(0, 7) == 0);
			endcase
			if (!held && sent_count >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b0;
			end
			rsp.ready <= nxt;
		end
	end

	// Ends the run when neither channel has moved a beat for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle = 0;
			else
				idle++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	initial begin : stimulus
		int k;
		bit full_done;
		sb          = new();
		sent_count  = 0;
		full_done   = 1'b0;
		burst_left  = $urandom_range(1, 20);
		arst_n      <= 1'b0;
		req.valid   <= 1'b0;
		req.kind    <= KIND_INSERT;
		req.key     <= '0;
		req.payload <= '0;
		req.index   <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The empty table first: nothing to find, erase or read.
		send_op(make_op(KIND_FIND, 32'h0000_1234, 0, 0));
		send_op(make_op(KIND_ERASE, 32'h0000_0000, 0, 0));
		send_op(make_op(KIND_READ, 0, 0, 0));
		// Keys at both ends of the range, and a duplicate that must land in
		// front of its older twin.
		send_op(make_op(KIND_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 8'hFF));
		send_op(make_op(KIND_INSERT, 32'h0000_0000, 32'h0000_0000, 0));
		send_op(make_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 0));
		send_op(make_op(KIND_INSERT, 32'h8000_0000, 32'h0000_0001, 0));
		send_op(make_op(KIND_INSERT, 32'h0000_0005, 32'h0000_FFFF, 0));
		send_op(make_op(KIND_FIND, 32'h8000_0000, 0, 0));
		send_op(make_op(KIND_FIND, 32'hFFFF_FFFF, 0, 0));
		send_op(make_op(KIND_FIND, 32'h0000_0000, 0, 0));
		send_op(make_op(KIND_FIND, 32'h0000_0007, 0, 0));
		// Reads at the first and last live slot, at the count, and at the top.
		send_op(make_op(KIND_READ, 0, 0, 0));
		send_op(make_op(KIND_READ, 0, 0, 4));
		send_op(make_op(KIND_READ, 0, 0, 5));
		send_op(make_op(KIND_READ, 0, 0, 8'hFF));
		send_op(make_op(KIND_ERASE, 32'h0000_0009, 0, 0));
		send_op(make_op(KIND_ERASE, 32'h8000_0000, 0, 0));
		send_op(make_op(KIND_ERASE, 32'hFFFF_FFFF, 0, 0));
		for (k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
			send_op(make_op(KIND_W'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
		send_op(make_op(KIND_CLEAR, 0, 0, 0));
		send_op(make_op(KIND_READ, 0, 0, 0));
		// A one-entry table must survive an erase of a key it does not hold.
		send_op(make_op(KIND_INSERT, 32'h0000_000A, 32'h1234_5678, 0));
		send_op(make_op(KIND_ERASE, 32'h0000_000B, 0, 0));
		send_op(make_op(KIND_ERASE, 32'h0000_000A, 0, 0));

		// Random part. Table sizes stay small most of the time; each stretch
		// picks its own ceiling. One run in the middle goes all the way up.
		k = 0;
		while (k < RANDOM_OPS) begin
			int cap, len;
			cap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(2, 16);
			len = $urandom_range(30, 80);
			repeat (len) begin
				send_op(pick_op(cap));
				k++;
			end
			if (!full_done && k >= FULL_AT) begin
				fill_to_full();
				full_done = 1'b1;
			end
		end
		// Nothing more to offer, so the last beat is not taken twice.
		req.valid <= 1'b0;

		// Let every outstanding response beat come back, then give the block
		// time to show any beat it should not produce.
		while (sb.expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end
endmodule
